### hw/rtl/frt_pkg.sv
// Shared types and codes for the fragment reassembly table.
package frt_pkg;

    localparam logic [1:0] CMD_FRAG     = 2'd0;
    localparam logic [1:0] CMD_EXPIRE   = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] STATUS_WAITING  = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ERROR    = 2'd2;
    localparam logic [1:0] STATUS_READ     = 2'd3;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_WAITING  = 2'd1;
    localparam logic [1:0] VERDICT_COMPLETE = 2'd2;
    localparam logic [1:0] VERDICT_ERROR    = 2'd3;

    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] seq_number;
        logic [32:0] seq_quot;
        logic [7:0]  fragment_index;
        logic [7:0]  fragment_total;
        logic [15:0] packet_length;
        logic [15:0] chunk_length;
        logic [7:0]  payload_byte;
        logic        byte_last;
        logic [31:0] now_time;
        logic [3:0]  read_slot;
        logic [10:0] read_offset;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t item;
    } head_t;

endpackage

### hw/rtl/frt_front.sv
// Front end: accepts items, drops unknown commands, precomputes the slot quotient.
module frt_front #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic           start,
    input  logic           busy,
    input  logic [1:0]     cmd,
    input  logic [31:0]    seq_number,
    input  logic [7:0]     fragment_index,
    input  logic [7:0]     fragment_total,
    input  logic [15:0]    packet_length,
    input  logic [15:0]    chunk_length,
    input  logic [7:0]     payload_byte,
    input  logic           byte_last,
    input  logic [31:0]    now_time,
    input  logic [3:0]     read_slot,
    input  logic [10:0]    read_offset,
    output logic           push,
    output frt_pkg::entry_t push_item
);

    localparam longint unsigned RECIP_W =
        ((64'd1 << 32) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [32:0] RECIP = RECIP_W[32:0];

    logic [64:0] quot_prod;

    assign quot_prod = 65'(seq_number) * 65'(RECIP);

    assign push = start && !busy && (cmd == frt_pkg::CMD_FRAG || cmd == frt_pkg::CMD_EXPIRE
                  || cmd == frt_pkg::CMD_READ);

    always_comb
    begin
        push_item.cmd            = cmd;
        push_item.seq_number     = seq_number;
        push_item.seq_quot       = quot_prod[64:32];
        push_item.fragment_index = fragment_index;
        push_item.fragment_total = fragment_total;
        push_item.packet_length  = packet_length;
        push_item.chunk_length   = chunk_length;
        push_item.payload_byte   = payload_byte;
        push_item.byte_last      = byte_last;
        push_item.now_time       = now_time;
        push_item.read_slot      = read_slot;
        push_item.read_offset    = read_offset;
    end

endmodule

### hw/rtl/frt_queue.sv
// Two-entry item queue between front and back end.
module frt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  frt_pkg::entry_t push_item,
    input  logic            pop,
    output frt_pkg::head_t  head,
    output logic            full
);

    frt_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule

### hw/rtl/frt_back.sv
// Back end: slot table, fragment runs, expire scan, buffer memory and results.
module frt_back #(
    parameter int TABLE_SLOTS   = 16,
    parameter int MAX_FRAGMENTS = 8,
    parameter int CHUNK_BYTES   = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  frt_pkg::head_t head,
    input  logic [31:0]    timeout_ticks,
    output logic           pop,
    output logic           result_valid,
    output logic [1:0]     status,
    output logic [3:0]     done_slot,
    output logic [15:0]    done_length,
    output logic [7:0]     read_byte
);

    localparam int SLOT_BYTES = MAX_FRAGMENTS * CHUNK_BYTES;
    localparam int MEM_DEPTH  = TABLE_SLOTS * SLOT_BYTES;
    localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int OFW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MF  = MAX_FRAGMENTS;

    typedef enum logic [1:0] {ST_RUN, ST_SCAN, ST_READ} state_t;

    state_t state_reg, state_next;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [MF-1:0]          rec_reg [TABLE_SLOTS];
    logic [MF-1:0]          rec_next [TABLE_SLOTS];
    logic [31:0]            seq_reg [TABLE_SLOTS];
    logic [15:0]            len_reg [TABLE_SLOTS];
    logic [3:0]             ft_reg [TABLE_SLOTS];
    logic [31:0]            time_reg [TABLE_SLOTS];
    logic [7:0]             buf_mem [MEM_DEPTH];

    logic [15:0]  run_position_reg, run_position_next;
    logic [1:0]   run_verdict_reg, run_verdict_next;
    logic [SW-1:0] run_slot_reg, run_slot_next;
    logic [OFW-1:0] run_base_reg, run_base_next;
    logic [15:0]  run_limit_reg, run_limit_next;
    logic [15:0]  run_length_reg, run_length_next;
    logic         run_write_reg, run_write_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [31:0]  scan_now_reg, scan_now_next;
    logic         rd_ok_reg, rd_ok_next;
    logic         res_valid_reg, res_valid_next;
    logic [1:0]   status_reg, status_next;
    logic [3:0]   done_slot_reg, done_slot_next;
    logic [15:0]  done_length_reg, done_length_next;
    logic [7:0]   read_byte_reg, read_byte_next;

    logic         init_we;
    logic [SW-1:0] init_slot;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]   mem_q;

    frt_pkg::entry_t it;
    logic [40:0]  quot_prod;
    logic [40:0]  rem_raw;
    logic [40:0]  rem_fix;
    logic [SW-1:0] slot;

    assign it        = head.item;
    assign quot_prod = 41'(it.seq_quot) * 41'(TABLE_SLOTS);
    assign rem_raw   = 41'(it.seq_number) - quot_prod;
    assign rem_fix   = rem_raw[40] ? (rem_raw + 41'(TABLE_SLOTS)) : rem_raw;
    assign slot      = rem_fix[SW-1:0];

    always_comb
    begin
        logic          first;
        logic          range_err;
        logic          cur_valid;
        logic [15:0]   len_eff;
        logic [3:0]    ft_eff;
        logic [MF-1:0] rec_eff;
        logic [MF-1:0] fbit;
        logic [MF-1:0] full_mask;
        logic [17:0]   end_off;
        logic [1:0]    verdict;
        logic          wr;
        logic [15:0]   pos;
        logic [15:0]   limit;
        logic [OFW-1:0] base;
        logic [SW-1:0] wslot;
        logic [31:0]   age;

        state_next        = state_reg;
        valid_next        = valid_reg;
        rec_next          = rec_reg;
        run_position_next = run_position_reg;
        run_verdict_next  = run_verdict_reg;
        run_slot_next     = run_slot_reg;
        run_base_next     = run_base_reg;
        run_limit_next    = run_limit_reg;
        run_length_next   = run_length_reg;
        run_write_next    = run_write_reg;
        scan_next         = scan_reg;
        scan_now_next     = scan_now_reg;
        rd_ok_next        = rd_ok_reg;
        res_valid_next    = 1'b0;
        status_next       = status_reg;
        done_slot_next    = done_slot_reg;
        done_length_next  = done_length_reg;
        read_byte_next    = read_byte_reg;
        pop               = 1'b0;
        init_we           = 1'b0;
        init_slot         = slot;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_raddr         = AW'(AW'(it.read_slot) * AW'(SLOT_BYTES)) + AW'(it.read_offset);

        first     = (run_verdict_reg == frt_pkg::VERDICT_NONE);
        range_err = (it.fragment_index >= it.fragment_total) ||
                    (it.fragment_total > 8'(MF));
        cur_valid = valid_reg[slot] && (seq_reg[slot] == it.seq_number);
        len_eff   = cur_valid ? len_reg[slot] : it.packet_length;
        ft_eff    = cur_valid ? ft_reg[slot] : it.fragment_total[3:0];
        rec_eff   = cur_valid ? rec_reg[slot] : '0;
        fbit      = MF'(1) << it.fragment_index[2:0];
        full_mask = MF'((9'd1 << ft_eff) - 9'd1);
        end_off   = 18'(18'(it.fragment_index) * 18'(CHUNK_BYTES)) + 18'(it.chunk_length);
        verdict   = run_verdict_reg;
        wr        = run_write_reg;
        pos       = run_position_reg;
        limit     = run_limit_reg;
        base      = run_base_reg;
        wslot     = run_slot_reg;
        age       = scan_now_reg - time_reg[scan_reg];

        unique case (state_reg)
            ST_RUN:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (it.cmd)
                        frt_pkg::CMD_FRAG:
                        begin
                            if (first)
                            begin
                                wr  = 1'b0;
                                pos = 16'd0;
                                if (range_err)
                                begin
                                    verdict = frt_pkg::VERDICT_ERROR;
                                end
                                else
                                begin
                                    wslot         = slot;
                                    run_slot_next = slot;
                                    init_we       = !cur_valid;
                                    valid_next[slot] = 1'b1;
                                    rec_next[slot]   = rec_eff;
                                    run_length_next  = len_eff;
                                    if (len_eff != it.packet_length ||
                                        8'(ft_eff) != it.fragment_total)
                                    begin
                                        verdict = frt_pkg::VERDICT_ERROR;
                                    end
                                    else if ((rec_eff & fbit) != '0)
                                    begin
                                        verdict = frt_pkg::VERDICT_WAITING;
                                    end
                                    else if (end_off > 18'(SLOT_BYTES))
                                    begin
                                        verdict = frt_pkg::VERDICT_ERROR;
                                    end
                                    else
                                    begin
                                        wr    = 1'b1;
                                        limit = it.chunk_length;
                                        base  = OFW'(OFW'(it.fragment_index) * OFW'(CHUNK_BYTES));
                                        rec_next[slot] = rec_eff | fbit;
                                        if ((rec_eff | fbit) == full_mask)
                                        begin
                                            valid_next[slot] = 1'b0;
                                            verdict = frt_pkg::VERDICT_COMPLETE;
                                        end
                                        else
                                        begin
                                            verdict = frt_pkg::VERDICT_WAITING;
                                        end
                                    end
                                end
                                run_base_next  = base;
                                run_limit_next = limit;
                            end
                            mem_waddr = AW'(AW'(wslot) * AW'(SLOT_BYTES)) + AW'(base) + AW'(pos);
                            if (wr && pos < limit)
                            begin
                                mem_we = 1'b1;
                                pos    = pos + 16'd1;
                            end
                            if (it.byte_last)
                            begin
                                res_valid_next   = 1'b1;
                                done_slot_next   = 4'd0;
                                done_length_next = 16'd0;
                                read_byte_next   = 8'd0;
                                unique case (verdict)
                                    frt_pkg::VERDICT_COMPLETE:
                                    begin
                                        status_next      = frt_pkg::STATUS_COMPLETE;
                                        done_slot_next   = 4'(wslot);
                                        done_length_next = first ? len_eff : run_length_reg;
                                    end
                                    frt_pkg::VERDICT_ERROR:
                                    begin
                                        status_next = frt_pkg::STATUS_ERROR;
                                    end
                                    default:
                                    begin
                                        status_next = frt_pkg::STATUS_WAITING;
                                    end
                                endcase
                                run_verdict_next  = frt_pkg::VERDICT_NONE;
                                run_position_next = 16'd0;
                                run_write_next    = 1'b0;
                            end
                            else
                            begin
                                run_verdict_next  = verdict;
                                run_position_next = pos;
                                run_write_next    = wr;
                            end
                        end
                        frt_pkg::CMD_EXPIRE:
                        begin
                            scan_next     = '0;
                            scan_now_next = it.now_time;
                            state_next    = ST_SCAN;
                        end
                        frt_pkg::CMD_READ:
                        begin
                            rd_ok_next = (32'(it.read_slot) < 32'(TABLE_SLOTS)) &&
                                         (32'(it.read_offset) < 32'(SLOT_BYTES));
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (valid_reg[scan_reg] && age > timeout_ticks)
                begin
                    valid_next[scan_reg] = 1'b0;
                    rec_next[scan_reg]   = '0;
                end
                if (scan_reg == SW'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end
            ST_READ:
            begin
                res_valid_next   = 1'b1;
                status_next      = frt_pkg::STATUS_READ;
                done_slot_next   = 4'd0;
                done_length_next = 16'd0;
                read_byte_next   = rd_ok_reg ? mem_q : 8'd0;
                state_next       = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            valid_reg        <= '0;
            rec_reg          <= '{default: '0};
            run_position_reg <= 16'd0;
            run_verdict_reg  <= frt_pkg::VERDICT_NONE;
            run_slot_reg     <= '0;
            run_base_reg     <= '0;
            run_limit_reg    <= 16'd0;
            run_length_reg   <= 16'd0;
            run_write_reg    <= 1'b0;
            scan_reg         <= '0;
            scan_now_reg     <= 32'd0;
            rd_ok_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
            status_reg       <= 2'd0;
            done_slot_reg    <= 4'd0;
            done_length_reg  <= 16'd0;
            read_byte_reg    <= 8'd0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            rec_reg          <= rec_next;
            run_position_reg <= run_position_next;
            run_verdict_reg  <= run_verdict_next;
            run_slot_reg     <= run_slot_next;
            run_base_reg     <= run_base_next;
            run_limit_reg    <= run_limit_next;
            run_length_reg   <= run_length_next;
            run_write_reg    <= run_write_next;
            scan_reg         <= scan_next;
            scan_now_reg     <= scan_now_next;
            rd_ok_reg        <= rd_ok_next;
            res_valid_reg    <= res_valid_next;
            status_reg       <= status_next;
            done_slot_reg    <= done_slot_next;
            done_length_reg  <= done_length_next;
            read_byte_reg    <= read_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            seq_reg[init_slot]  <= it.seq_number;
            len_reg[init_slot]  <= it.packet_length;
            ft_reg[init_slot]   <= it.fragment_total[3:0];
            time_reg[init_slot] <= it.now_time;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[mem_waddr] <= it.payload_byte;
        end
        mem_q <= buf_mem[mem_raddr];
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign done_slot    = done_slot_reg;
    assign done_length  = done_length_reg;
    assign read_byte    = read_byte_reg;

endmodule

### hw/rtl/fragment_reassembly_table_top.sv
// Fragment byte item: queued; result registered on byte_last; one item per cycle unless held.
// Read item: queued, then buffer read and result registered; holds the back end in ST_READ.
// Expire item: holds the back end in ST_SCAN, which checks one slot per cycle; no result.
// A two-entry queue parts front and back; busy rises only when it is full.
// Reset clears valid bits, received masks, run state and the queue; the buffer is not cleared.
// Results show for one cycle on result_valid; the receiver cannot stall.
module fragment_reassembly_table_top #(
    parameter int TABLE_SLOTS   = 16,
    parameter int MAX_FRAGMENTS = 8,
    parameter int CHUNK_BYTES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] seq_number,
    input  logic [7:0]  fragment_index,
    input  logic [7:0]  fragment_total,
    input  logic [15:0] packet_length,
    input  logic [15:0] chunk_length,
    input  logic [7:0]  payload_byte,
    input  logic        byte_last,
    input  logic [31:0] now_time,
    input  logic [3:0]  read_slot,
    input  logic [10:0] read_offset,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [3:0]  done_slot,
    output logic [15:0] done_length,
    output logic [7:0]  read_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]      timeout_reg;
    logic             push;
    logic             pop;
    frt_pkg::entry_t  push_item;
    frt_pkg::head_t   head;

    assign pready = 1'b1;
    assign prdata = (paddr == frt_pkg::ADDR_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 32'd1000000;
        end
        else if (psel && penable && pwrite && paddr == frt_pkg::ADDR_TIMEOUT)
        begin
            timeout_reg <= pwdata;
        end
    end

    frt_front #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_front (
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .seq_number     (seq_number),
        .fragment_index (fragment_index),
        .fragment_total (fragment_total),
        .packet_length  (packet_length),
        .chunk_length   (chunk_length),
        .payload_byte   (payload_byte),
        .byte_last      (byte_last),
        .now_time       (now_time),
        .read_slot      (read_slot),
        .read_offset    (read_offset),
        .push           (push),
        .push_item      (push_item)
    );

    frt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (busy)
    );

    frt_back #(
        .TABLE_SLOTS   (TABLE_SLOTS),
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .CHUNK_BYTES   (CHUNK_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .timeout_ticks (timeout_reg),
        .pop           (pop),
        .result_valid  (result_valid),
        .status        (status),
        .done_slot     (done_slot),
        .done_length   (done_length),
        .read_byte     (read_byte)
    );

endmodule

### tb/frt_checker.sv
// Checker for the fragment reassembly table: predicts each expected result and compares them.
module frt_checker #(
    parameter logic [2:0] TIMEOUT_ADDR = 3'd0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic [1:0]     cmd,
    input  logic [31:0]    seq_number,
    input  logic [7:0]     fragment_index,
    input  logic [7:0]     fragment_total,
    input  logic [15:0]    packet_length,
    input  logic [15:0]    chunk_length,
    input  logic [7:0]     payload_byte,
    input  logic           byte_last,
    input  logic [31:0]    now_time,
    input  logic [3:0]     read_slot,
    input  logic [10:0]    read_offset,
    input  logic           result_valid,
    input  logic [1:0]     status,
    input  logic [3:0]     done_slot,
    input  logic [15:0]    done_length,
    input  logic [7:0]     read_byte,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             errors,
    output int             pending,
    output logic [32767:0] written
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 16;
    localparam int FRAGS     = 8;
    localparam int CHUNK     = 256;
    localparam int SLOT_SIZE = FRAGS * CHUNK;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [15:0] length;
        logic [7:0]  rbyte;
    } outcome_t;

    outcome_t    outcome_q[$];

    logic [31:0] timeout;
    logic        valid_r    [SLOTS];
    logic [31:0] seq_r      [SLOTS];
    logic [15:0] length_r   [SLOTS];
    logic [3:0]  total_r    [SLOTS];
    logic [31:0] stamp_r    [SLOTS];
    logic [7:0]  received_r [SLOTS];
    logic [7:0]  buffer_r   [SLOTS*SLOT_SIZE];
    logic [15:0] run_pos;
    logic [1:0]  run_verdict;
    int          run_slot;
    int          run_base;
    int          run_limit;
    logic        run_write;

    function automatic logic [1:0] open_fragment();
        int         s;
        logic [7:0] bit_m;
        logic [7:0] full;
        run_write = 1'b0;
        if (fragment_index >= fragment_total || fragment_total > FRAGS)
            return frt_pkg::VERDICT_ERROR;
        s = int'(seq_number % SLOTS);
        run_slot = s;
        if (valid_r[s] && seq_r[s] != seq_number)
        begin
            valid_r[s] = 1'b0;
            received_r[s] = '0;
        end
        if (!valid_r[s])
        begin
            seq_r[s] = seq_number;
            length_r[s] = packet_length;
            total_r[s] = fragment_total[3:0];
            stamp_r[s] = now_time;
            received_r[s] = '0;
            valid_r[s] = 1'b1;
        end
        if (length_r[s] != packet_length || {4'd0, total_r[s]} != fragment_total)
            return frt_pkg::VERDICT_ERROR;
        bit_m = 8'd1 << fragment_index;
        if ((received_r[s] & bit_m) != 8'd0)
            return frt_pkg::VERDICT_WAITING;
        run_base = int'(fragment_index) * CHUNK;
        if (run_base + int'(chunk_length) > SLOT_SIZE)
            return frt_pkg::VERDICT_ERROR;
        run_limit = int'(chunk_length);
        run_write = 1'b1;
        received_r[s] = received_r[s] | bit_m;
        full = 8'((9'd1 << total_r[s]) - 9'd1);
        if (received_r[s] == full)
        begin
            valid_r[s] = 1'b0;
            return frt_pkg::VERDICT_COMPLETE;
        end
        return frt_pkg::VERDICT_WAITING;
    endfunction

    task automatic predict_item();
        outcome_t o;
        int       a;
        o = '0;
        if (cmd == frt_pkg::CMD_EXPIRE)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (valid_r[i] && 32'(now_time - stamp_r[i]) > timeout)
                begin
                    valid_r[i] = 1'b0;
                    received_r[i] = '0;
                end
        end
        else if (cmd == frt_pkg::CMD_READ)
        begin
            o.status = frt_pkg::STATUS_READ;
            o.rbyte = buffer_r[int'(read_slot) * SLOT_SIZE + int'(read_offset)];
            outcome_q.push_back(o);
        end
        else if (cmd == frt_pkg::CMD_FRAG)
        begin
            if (run_verdict == frt_pkg::VERDICT_NONE)
            begin
                run_pos = '0;
                run_verdict = open_fragment();
            end
            if (run_write && int'(run_pos) < run_limit)
            begin
                a = run_slot * SLOT_SIZE + run_base + int'(run_pos);
                buffer_r[a] = payload_byte;
                written[a] = 1'b1;
                run_pos = run_pos + 16'd1;
            end
            if (byte_last)
            begin
                if (run_verdict == frt_pkg::VERDICT_COMPLETE)
                begin
                    o.status = frt_pkg::STATUS_COMPLETE;
                    o.slot = run_slot[3:0];
                    o.length = length_r[run_slot];
                end
                else if (run_verdict == frt_pkg::VERDICT_ERROR)
                    o.status = frt_pkg::STATUS_ERROR;
                else
                    o.status = frt_pkg::STATUS_WAITING;
                outcome_q.push_back(o);
                run_verdict = frt_pkg::VERDICT_NONE;
                run_pos = '0;
                run_write = 1'b0;
            end
        end
    endtask

    task automatic check_result();
        outcome_t o;
        if (outcome_q.size() == 0)
        begin
            $error("result with nothing expected: status %0d", status);
            errors++;
            return;
        end
        o = outcome_q.pop_front();
        if (status !== o.status)
        begin
            $error("status: expected %0d, got %0d", o.status, status);
            errors++;
        end
        if (done_slot !== o.slot)
        begin
            $error("done_slot: expected %0d, got %0d", o.slot, done_slot);
            errors++;
        end
        if (done_length !== o.length)
        begin
            $error("done_length: expected %0d, got %0d", o.length, done_length);
            errors++;
        end
        if (read_byte !== o.rbyte)
        begin
            $error("read_byte: expected %0d, got %0d", o.rbyte, read_byte);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        written = '0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            timeout = 32'd1000000;
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_r[i] = 1'b0;
                received_r[i] = '0;
                seq_r[i] = '0;
                length_r[i] = '0;
                total_r[i] = '0;
                stamp_r[i] = '0;
            end
            run_pos = '0;
            run_verdict = frt_pkg::VERDICT_NONE;
            run_slot = 0;
            run_base = 0;
            run_limit = 0;
            run_write = 1'b0;
        end
        else
        begin
            if (result_valid)
                check_result();
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                timeout = pwdata;
            if (start && !busy)
                predict_item();
        end
        pending = outcome_q.size();
    end
endmodule

### tb/tb.sv
// Testbench top for the fragment reassembly table: stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_TIMEOUT = frt_pkg::ADDR_TIMEOUT;
    localparam int         STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = frt_pkg::CMD_FRAG;
    logic [31:0] seq_number = '0;
    logic [7:0]  fragment_index = '0;
    logic [7:0]  fragment_total = '0;
    logic [15:0] packet_length = '0;
    logic [15:0] chunk_length = '0;
    logic [7:0]  payload_byte = '0;
    logic        byte_last = 1'b0;
    logic [31:0] now_time = '0;
    logic [3:0]  read_slot = '0;
    logic [10:0] read_offset = '0;
    logic        result_valid;
    logic [1:0]  status;
    logic [3:0]  done_slot;
    logic [15:0] done_length;
    logic [7:0]  read_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int             errors;
    int             pending;
    logic [32767:0] written;
    int             item_count = 0;
    int             idle_count = 0;
    bit             burst = 1'b0;
    logic [31:0]    clock_now;

    always #5 clk = ~clk;

    fragment_reassembly_table_top dut (.*);

    frt_checker #(.TIMEOUT_ADDR(REG_TIMEOUT)) u_checker (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic issue();
        int gap;
        logic was_busy;
        gap = burst ? 0 : int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        do
        begin
            was_busy = busy;
            @(posedge clk);
            @(negedge clk);
        end
        while (was_busy);
        item_count++;
        if ($urandom_range(0, 40) == 0)
            burst = ~burst;
    endtask

    task automatic fill_noise();
        payload_byte = 8'($urandom);
        read_slot = 4'($urandom);
        read_offset = 11'($urandom);
    endtask

    task automatic frag_run(input logic [31:0] sq, input logic [7:0] fi, input logic [7:0] ft,
                            input logic [15:0] pl, input logic [15:0] cl, input int n);
        for (int k = 0; k < n; k++)
        begin
            fill_noise();
            cmd = frt_pkg::CMD_FRAG;
            seq_number = (k == 0) ? sq : 32'($urandom);
            fragment_index = (k == 0) ? fi : 8'($urandom);
            fragment_total = (k == 0) ? ft : 8'($urandom);
            packet_length = (k == 0) ? pl : 16'($urandom);
            chunk_length = (k == 0) ? cl : 16'($urandom);
            now_time = clock_now;
            byte_last = (k == n - 1);
            issue();
        end
    endtask

    task automatic expire_scan(input logic [31:0] t);
        fill_noise();
        cmd = frt_pkg::CMD_EXPIRE;
        now_time = t;
        byte_last = 1'($urandom);
        seq_number = 32'($urandom);
        issue();
    endtask

    task automatic read_any();
        int a;
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 40 && !hit; k++)
        begin
            a = int'($urandom_range(0, 32767));
            hit = written[a];
        end
        if (!hit)
        begin
            a = int'($urandom_range(0, 32767));
            for (int k = 0; k < 32768 && !hit; k++)
            begin
                a = (a + 1) % 32768;
                hit = written[a];
            end
        end
        if (!hit)
            return;
        fill_noise();
        cmd = frt_pkg::CMD_READ;
        read_slot = 4'(a / 2048);
        read_offset = 11'(a % 2048);
        byte_last = 1'($urandom);
        now_time = 32'($urandom);
        issue();
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        start = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic settle();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_packet();
        logic [31:0] sq;
        logic [7:0]  ft;
        logic [15:0] pl;
        logic [7:0]  order[$];
        logic [7:0]  fi;
        int          cl;
        int          n;
        int          pick;
        sq = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
        ft = 8'($urandom_range(1, 8));
        pl = 16'($urandom);
        for (int i = 0; i < ft; i++)
            order.insert(int'($urandom_range(0, order.size())), i[7:0]);
        foreach (order[i])
        begin
            fi = order[i];
            cl = int'($urandom_range(0, 5));
            n = cl + int'($urandom_range(0, 2)) - 1;
            if (n < 1)
                n = 1;
            pick = int'($urandom_range(0, 19));
            clock_now = clock_now + 32'($urandom_range(0, 20));
            case (pick)
                0: frag_run(sq, ft, ft, pl, 16'(cl), n);
                1: frag_run(sq, fi, ft, pl ^ 16'h1, 16'(cl), n);
                2: frag_run(sq, fi, ft, pl, 16'($urandom_range(1793, 65535)), 2);
                3: frag_run(sq, fi, 8'($urandom_range(9, 255)), pl, 16'(cl), n);
                default: frag_run(sq, fi, ft, pl, 16'(cl), n);
            endcase
            if (pick == 4)
                frag_run(sq, fi, ft, pl, 16'(cl), n);
            case ($urandom_range(0, 9))
                0: read_any();
                1: expire_scan(clock_now + 32'($urandom_range(0, 80)));
                2:
                begin
                    fill_noise();
                    cmd = frt_pkg::CMD_RESERVED;
                    byte_last = 1'b1;
                    issue();
                end
                default: ;
            endcase
        end
    endtask

    initial
    begin
        logic [31:0] limits[4];
        limits = '{32'd0, 32'd30, 32'hFFFFFFFF, 32'($urandom)};
        clock_now = 32'($urandom);
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        frag_run(32'd0, 8'd0, 8'd1, 16'hFFFF, 16'd1, 1);
        frag_run(32'hFFFFFFFF, 8'd0, 8'd2, 16'd0, 16'd3, 4);
        frag_run(32'hFFFFFFFF, 8'd0, 8'd2, 16'd0, 16'd3, 1);
        frag_run(32'hFFFFFFFF, 8'd1, 8'd2, 16'd1, 16'd0, 1);
        frag_run(32'hFFFFFFFF, 8'd1, 8'd2, 16'd0, 16'd2, 2);
        frag_run(32'd5, 8'd0, 8'd0, 16'd9, 16'd1, 1);
        frag_run(32'd5, 8'd8, 8'd8, 16'd9, 16'd1, 1);
        frag_run(32'd5, 8'd0, 8'd255, 16'd9, 16'd1, 1);
        frag_run(32'd5, 8'd7, 8'd8, 16'd9, 16'hFFFF, 2);
        frag_run(32'd5, 8'd7, 8'd8, 16'd9, 16'd256, 3);
        frag_run(32'd21, 8'd0, 8'd3, 16'd4, 16'd1, 1);
        read_any();
        expire_scan(clock_now);
        fill_noise();
        cmd = frt_pkg::CMD_RESERVED;
        byte_last = 1'b1;
        issue();
        settle();
        apb_write(REG_TIMEOUT, 32'd0);
        clock_now = clock_now + 32'd1;
        expire_scan(clock_now);
        frag_run(32'd21, 8'd1, 8'd3, 16'd4, 16'd1, 1);
        settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                apb_write(REG_TIMEOUT, limits[ph - 1]);
            end
            while (item_count < 200 * (ph + 1) - 100)
                random_packet();
        end
        settle();
        apb_write(REG_TIMEOUT, 32'd1000000);
        random_packet();
        settle();

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### files.f
hw/rtl/frt_pkg.sv
hw/rtl/frt_front.sv
hw/rtl/frt_queue.sv
hw/rtl/frt_back.sv
hw/rtl/fragment_reassembly_table_top.sv
tb/frt_checker.sv
tb/tb.sv
